// File: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants and types for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// Default coordinate width and weight fraction width.
	localparam int CPT_COORD_BITS       = 16;
	localparam int CPT_WEIGHT_FRAC_BITS = 16;

	// Two division lanes: lane 0 gives weight b, lane 1 gives weight c.
	localparam int CPT_LANES = 2;

	// Voronoi region codes as they appear on the region port.
	typedef enum logic [2:0] {
		REG_A  = 3'd0,
		REG_B  = 3'd1,
		REG_AB = 3'd2,
		REG_C  = 3'd3,
		REG_AC = 3'd4,
		REG_BC = 3'd5,
		REG_IN = 3'd6
	} region_t;

	// Outcomes of the dot-product sign tests, carried down the region stages.
	typedef struct packed {
		logic ca;   // vertex a test
		logic cb;   // vertex b test
		logic cab;  // dot-product half of the edge ab test
		logic cc;   // vertex c test
		logic cac;  // dot-product half of the edge ac test
		logic cbc;  // dot-product half of the edge bc test
	} dflags_t;

endpackage

// File: rtl/cpt_dot.sv
// ----------------------------------------------------------------------------
// cpt_dot
// Three-stage dot-product front end: edge and offset vectors, the eighteen
// coordinate products, then the six dot products d1 to d6.
// ----------------------------------------------------------------------------
module cpt_dot #(
	parameter int  COORD_BITS = cpt_pkg::CPT_COORD_BITS,
	localparam int DOTW       = 2 * COORD_BITS + 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [COORD_BITS-1:0]   p [3],
	input  logic signed [COORD_BITS-1:0]   a [3],
	input  logic signed [COORD_BITS-1:0]   b [3],
	input  logic signed [COORD_BITS-1:0]   c [3],
	output logic                           out_vld,
	output logic signed [DOTW-1:0]         d [6],
	output logic [8:0][COORD_BITS-1:0]     vtx
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0]         ab_s1 [3];
	logic signed [DW-1:0]         ac_s1 [3];
	logic signed [DW-1:0]         ap_s1 [3];
	logic signed [DW-1:0]         bp_s1 [3];
	logic signed [DW-1:0]         cp_s1 [3];
	logic signed [PW-1:0]         m_s2 [6][3];
	logic signed [DOTW-1:0]       d_s3 [6];
	logic [8:0][COORD_BITS-1:0]   vtx_s1, vtx_s2, vtx_s3;
	logic                         vld_s1, vld_s2, vld_s3;

	function automatic logic signed [DW-1:0] ext(input logic signed [COORD_BITS-1:0] v);
		return DW'(v);
	endfunction

	// Valid bits travel with the data and freeze on a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: edge vectors and offsets of the query point.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ab_s1[k]      <= ext(b[k]) - ext(a[k]);
				ac_s1[k]      <= ext(c[k]) - ext(a[k]);
				ap_s1[k]      <= ext(p[k]) - ext(a[k]);
				bp_s1[k]      <= ext(p[k]) - ext(b[k]);
				cp_s1[k]      <= ext(p[k]) - ext(c[k]);
				vtx_s1[k]     <= a[k];
				vtx_s1[3 + k] <= b[k];
				vtx_s1[6 + k] <= c[k];
			end
		end
	end

	// Stage 2: per-coordinate products for each of the six dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m_s2[0][k] <= PW'(ab_s1[k]) * PW'(ap_s1[k]);
				m_s2[1][k] <= PW'(ac_s1[k]) * PW'(ap_s1[k]);
				m_s2[2][k] <= PW'(ab_s1[k]) * PW'(bp_s1[k]);
				m_s2[3][k] <= PW'(ac_s1[k]) * PW'(bp_s1[k]);
				m_s2[4][k] <= PW'(ab_s1[k]) * PW'(cp_s1[k]);
				m_s2[5][k] <= PW'(ac_s1[k]) * PW'(cp_s1[k]);
			end
			vtx_s2 <= vtx_s1;
		end
	end

	// Stage 3: sum the three coordinate products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				d_s3[j] <= DOTW'(m_s2[j][0]) + DOTW'(m_s2[j][1]) + DOTW'(m_s2[j][2]);
			end
			vtx_s3 <= vtx_s2;
		end
	end

	assign out_vld = vld_s3;
	assign d       = d_s3;
	assign vtx     = vtx_s3;

endmodule

// File: rtl/cpt_region.sv
// ----------------------------------------------------------------------------
// cpt_region
// Four-stage region classifier: split products for the three determinants,
// their assembly, the determinants themselves, then the region choice and
// the numerator and denominator handed to each division lane.
// ----------------------------------------------------------------------------
module cpt_region #(
	parameter int  COORD_BITS = cpt_pkg::CPT_COORD_BITS,
	localparam int DOTW       = 2 * COORD_BITS + 4,
	localparam int NW         = 4 * COORD_BITS + 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [DOTW-1:0]         d [6],
	input  logic [8:0][COORD_BITS-1:0]     vtx_in,
	output logic                           out_vld,
	output cpt_pkg::region_t               rgn,
	output logic signed [NW-1:0]           num [cpt_pkg::CPT_LANES],
	output logic signed [NW-1:0]           den [cpt_pkg::CPT_LANES],
	output logic [8:0][COORD_BITS-1:0]     vtx_out
);

	import cpt_pkg::*;

	localparam int H   = (DOTW + 1) / 2;
	localparam int HH  = DOTW - H;
	localparam int LLW = 2 * H;
	localparam int LHW = H + 1 + HH;
	localparam int HHW = 2 * HH;
	localparam int VPW = 2 * DOTW;
	localparam int VW  = VPW + 1;
	localparam int EW  = DOTW + 1;
	localparam int E5W = EW + 1;

	// Operand pairs of the six determinant products, as indexes into d1..d6.
	localparam int OPA [6] = '{0, 2, 4, 0, 2, 4};
	localparam int OPB [6] = '{3, 1, 1, 5, 5, 3};

	logic [H-1:0]                 lo_c [6];
	logic signed [HH-1:0]         hi_c [6];
	logic signed [EW-1:0]         e_c [4];
	dflags_t                      flg_c;

	logic [LLW-1:0]               pll_s4 [6];
	logic signed [LHW-1:0]        plh_s4 [6];
	logic signed [LHW-1:0]        phl_s4 [6];
	logic signed [HHW-1:0]        phh_s4 [6];
	logic signed [EW-1:0]         e_s4 [4];
	logic signed [DOTW-1:0]       n_s4 [2];
	dflags_t                      flg_s4;

	logic signed [VPW-1:0]        p_s5 [6];
	logic signed [EW-1:0]         e_s5 [3];
	logic signed [E5W-1:0]        e5_s5;
	logic signed [DOTW-1:0]       n_s5 [2];
	dflags_t                      flg_s5;

	logic signed [VW-1:0]         v_s6 [3];
	logic signed [EW-1:0]         e_s6 [3];
	logic signed [E5W-1:0]        e5_s6;
	logic signed [DOTW-1:0]       n_s6 [2];
	dflags_t                      flg_s6;

	logic signed [NW-1:0]         sum_c;
	logic                         le0_c [3];
	region_t                      rg_c;
	logic signed [NW-1:0]         num_c [CPT_LANES];
	logic signed [NW-1:0]         den_c [CPT_LANES];

	region_t                      rgn_s7;
	logic signed [NW-1:0]         num_s7 [CPT_LANES];
	logic signed [NW-1:0]         den_s7 [CPT_LANES];

	logic [8:0][COORD_BITS-1:0]   vtx_s4, vtx_s5, vtx_s6, vtx_s7;
	logic                         vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Halves of each dot product and the sign tests on them.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			lo_c[i] = d[i][H-1:0];
			hi_c[i] = $signed(d[i][DOTW-1:H]);
		end
		e_c[0] = EW'(d[0]) - EW'(d[2]);
		e_c[1] = EW'(d[1]) - EW'(d[5]);
		e_c[2] = EW'(d[3]) - EW'(d[2]);
		e_c[3] = EW'(d[4]) - EW'(d[5]);
		flg_c.ca  = (d[0][DOTW-1] || d[0] == '0) && (d[1][DOTW-1] || d[1] == '0);
		flg_c.cb  = !d[2][DOTW-1] && (d[3] <= d[2]);
		flg_c.cab = !d[0][DOTW-1] && (d[2][DOTW-1] || d[2] == '0);
		flg_c.cc  = !d[5][DOTW-1] && (d[4] <= d[5]);
		flg_c.cac = !d[1][DOTW-1] && (d[5][DOTW-1] || d[5] == '0);
		flg_c.cbc = !e_c[2][EW-1] && !e_c[3][EW-1];
	end

	// Stage 4: four partial products for each determinant product.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 6; n++) begin
				pll_s4[n] <= LLW'(lo_c[OPA[n]]) * LLW'(lo_c[OPB[n]]);
				plh_s4[n] <= LHW'($signed({1'b0, lo_c[OPA[n]]})) * LHW'(hi_c[OPB[n]]);
				phl_s4[n] <= LHW'(hi_c[OPA[n]]) * LHW'($signed({1'b0, lo_c[OPB[n]]}));
				phh_s4[n] <= HHW'(hi_c[OPA[n]]) * HHW'(hi_c[OPB[n]]);
			end
			e_s4   <= e_c;
			n_s4[0] <= d[0];
			n_s4[1] <= d[1];
			flg_s4 <= flg_c;
			vtx_s4 <= vtx_in;
		end
	end

	// Stage 5: assemble the full products; edge bc denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 6; n++) begin
				p_s5[n] <= (VPW'(phh_s4[n]) << (2 * H))
					+ ((VPW'(plh_s4[n]) + VPW'(phl_s4[n])) << H)
					+ VPW'(pll_s4[n]);
			end
			e_s5[0] <= e_s4[0];
			e_s5[1] <= e_s4[1];
			e_s5[2] <= e_s4[2];
			e5_s5   <= E5W'(e_s4[2]) + E5W'(e_s4[3]);
			n_s5    <= n_s4;
			flg_s5  <= flg_s4;
			vtx_s5  <= vtx_s4;
		end
	end

	// Stage 6: determinants va, vb and vc.
	always_ff @(posedge clk) begin
		if (en) begin
			v_s6[0] <= VW'(p_s5[4]) - VW'(p_s5[5]);
			v_s6[1] <= VW'(p_s5[2]) - VW'(p_s5[3]);
			v_s6[2] <= VW'(p_s5[0]) - VW'(p_s5[1]);
			e_s6    <= e_s5;
			e5_s6   <= e5_s5;
			n_s6    <= n_s5;
			flg_s6  <= flg_s5;
			vtx_s6  <= vtx_s5;
		end
	end

	// Region choice in priority order, and the operands for each lane.
	always_comb begin
		sum_c = NW'(v_s6[0]) + NW'(v_s6[1]) + NW'(v_s6[2]);
		for (int i = 0; i < 3; i++) begin
			le0_c[i] = v_s6[i][VW-1] || (v_s6[i] == '0);
		end
		rg_c = REG_IN;
		for (int l = 0; l < CPT_LANES; l++) begin
			num_c[l] = '0;
			den_c[l] = '0;
		end
		if (flg_s6.ca) begin
			rg_c = REG_A;
		end else if (flg_s6.cb) begin
			rg_c = REG_B;
		end else if (le0_c[2] && flg_s6.cab) begin
			rg_c     = REG_AB;
			num_c[0] = NW'(n_s6[0]);
			den_c[0] = NW'(e_s6[0]);
		end else if (flg_s6.cc) begin
			rg_c = REG_C;
		end else if (le0_c[1] && flg_s6.cac) begin
			rg_c     = REG_AC;
			num_c[1] = NW'(n_s6[1]);
			den_c[1] = NW'(e_s6[1]);
		end else if (le0_c[0] && flg_s6.cbc) begin
			rg_c     = REG_BC;
			num_c[1] = NW'(e_s6[2]);
			den_c[1] = NW'(e5_s6);
		end else begin
			num_c[0] = NW'(v_s6[1]);
			den_c[0] = sum_c;
			num_c[1] = NW'(v_s6[2]);
			den_c[1] = sum_c;
		end
	end

	// Stage 7: register the choice.
	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s7 <= rg_c;
			num_s7 <= num_c;
			den_s7 <= den_c;
			vtx_s7 <= vtx_s6;
		end
	end

	assign out_vld = vld_s7;
	assign rgn     = rgn_s7;
	assign num     = num_s7;
	assign den     = den_s7;
	assign vtx_out = vtx_s7;

endmodule

// File: rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Two-lane pipelined divider for clamped ratios in Q1.WEIGHT_FRAC_BITS:
// a sign and magnitude stage, a saturation compare, one restoring step per
// quotient bit, then rounding half up.
// ----------------------------------------------------------------------------
module cpt_div #(
	parameter int  COORD_BITS       = cpt_pkg::CPT_COORD_BITS,
	parameter int  WEIGHT_FRAC_BITS = cpt_pkg::CPT_WEIGHT_FRAC_BITS,
	parameter int  SBW              = 1,
	localparam int NW               = 4 * COORD_BITS + 11,
	localparam int WW               = WEIGHT_FRAC_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [NW-1:0]   num [cpt_pkg::CPT_LANES],
	input  logic signed [NW-1:0]   den [cpt_pkg::CPT_LANES],
	input  logic [SBW-1:0]         side_in,
	output logic                   out_vld,
	output logic [WW-1:0]          q [cpt_pkg::CPT_LANES],
	output logic                   dz [cpt_pkg::CPT_LANES],
	output logic [SBW-1:0]         side_out
);

	import cpt_pkg::*;

	localparam int LAT = WW + 3;
	localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS;

	// Magnitude stage.
	logic              z_s1 [CPT_LANES];
	logic              dz_s1 [CPT_LANES];
	logic [NW-1:0]     an_s1 [CPT_LANES];
	logic [NW-1:0]     ad_s1 [CPT_LANES];

	// Iteration stages; index 0 is the saturation compare.
	logic [NW-1:0]     rem_sn [WW+1][CPT_LANES];
	logic [NW-1:0]     dv_sn [WW+1][CPT_LANES];
	logic [WW-1:0]     q_sn [WW+1][CPT_LANES];
	logic              z_sn [WW+1][CPT_LANES];
	logic              o_sn [WW+1][CPT_LANES];
	logic              dz_sn [WW+1][CPT_LANES];

	// Rounded result.
	logic [WW-1:0]     res_sf [CPT_LANES];
	logic              dz_sf [CPT_LANES];

	logic [NW:0]       r2_c [WW][CPT_LANES];
	logic [NW:0]       sub_c [WW][CPT_LANES];
	logic              ge_c [WW][CPT_LANES];
	logic [WW:0]       rnd_c [CPT_LANES];

	logic              vld_sn [LAT];
	logic [SBW-1:0]    side_sn [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < LAT; s++) begin
				vld_sn[s] <= 1'b0;
			end
		end else if (en) begin
			vld_sn[0] <= in_vld;
			for (int s = 1; s < LAT; s++) begin
				vld_sn[s] <= vld_sn[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sn[0] <= side_in;
			for (int s = 1; s < LAT; s++) begin
				side_sn[s] <= side_sn[s-1];
			end
		end
	end

	// One restoring step per stage: shift, compare, subtract.
	always_comb begin
		for (int i = 0; i < WW; i++) begin
			for (int l = 0; l < CPT_LANES; l++) begin
				r2_c[i][l]  = {rem_sn[i][l], 1'b0};
				sub_c[i][l] = r2_c[i][l] - {1'b0, dv_sn[i][l]};
				ge_c[i][l]  = r2_c[i][l] >= {1'b0, dv_sn[i][l]};
			end
		end
		for (int l = 0; l < CPT_LANES; l++) begin
			rnd_c[l] = {1'b0, q_sn[WW][l]} + (WW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < CPT_LANES; l++) begin
				// A zero operand or opposite signs give a zero weight.
				z_s1[l]  <= (den[l] == '0) || (num[l] == '0)
					|| (num[l][NW-1] != den[l][NW-1]);
				dz_s1[l] <= (den[l] == '0);
				an_s1[l] <= num[l][NW-1] ? (~num[l] + NW'(1)) : num[l];
				ad_s1[l] <= den[l][NW-1] ? (~den[l] + NW'(1)) : den[l];

				// A ratio of one or more saturates at one.
				o_sn[0][l]   <= an_s1[l] >= ad_s1[l];
				rem_sn[0][l] <= an_s1[l];
				dv_sn[0][l]  <= ad_s1[l];
				q_sn[0][l]   <= '0;
				z_sn[0][l]   <= z_s1[l];
				dz_sn[0][l]  <= dz_s1[l];

				for (int i = 0; i < WW; i++) begin
					rem_sn[i+1][l] <= ge_c[i][l] ? sub_c[i][l][NW-1:0] : r2_c[i][l][NW-1:0];
					dv_sn[i+1][l]  <= dv_sn[i][l];
					q_sn[i+1][l]   <= {q_sn[i][l][WW-2:0], ge_c[i][l]};
					z_sn[i+1][l]   <= z_sn[i][l];
					o_sn[i+1][l]   <= o_sn[i][l];
					dz_sn[i+1][l]  <= dz_sn[i][l];
				end

				// Round half up by dropping the guard bit.
				if (z_sn[WW][l]) begin
					res_sf[l] <= '0;
				end else if (o_sn[WW][l]) begin
					res_sf[l] <= ONE;
				end else begin
					res_sf[l] <= rnd_c[l][WW:1];
				end
				dz_sf[l] <= dz_sn[WW][l];
			end
		end
	end

	assign out_vld  = vld_sn[LAT-1];
	assign side_out = side_sn[LAT-1];
	assign q        = res_sf;
	assign dz       = dz_sf;

endmodule

// File: rtl/cpt_blend.sv
// ----------------------------------------------------------------------------
// cpt_blend
// Three-stage back end: final barycentric weights per region, weighted
// vertex products, then the rounded and saturated closest point.
// ----------------------------------------------------------------------------
module cpt_blend #(
	parameter int  COORD_BITS       = cpt_pkg::CPT_COORD_BITS,
	parameter int  WEIGHT_FRAC_BITS = cpt_pkg::CPT_WEIGHT_FRAC_BITS,
	localparam int WW               = WEIGHT_FRAC_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  cpt_pkg::region_t               rgn_in,
	input  logic [WW-1:0]                  q [cpt_pkg::CPT_LANES],
	input  logic                           dz,
	input  logic [8:0][COORD_BITS-1:0]     vtx,
	output logic                           out_vld,
	output logic signed [COORD_BITS-1:0]   near [3],
	output logic [WW-1:0]                  w [3],
	output cpt_pkg::region_t               rgn_out,
	output logic                           dgn
);

	import cpt_pkg::*;

	localparam int PRW = WW + 1 + COORD_BITS;
	localparam int PSW = PRW + 2;
	localparam int RW  = PSW - WEIGHT_FRAC_BITS;
	localparam logic [WW-1:0]         ONE  = WW'(1) << WEIGHT_FRAC_BITS;
	localparam logic signed [PSW-1:0] HALF = PSW'(1) <<< (WEIGHT_FRAC_BITS - 1);
	localparam logic signed [RW-1:0]  LIM  = (RW'(1) <<< (COORD_BITS - 1)) - RW'(1);
	localparam logic signed [RW-1:0]  MINV = -LIM - RW'(1);

	logic [WW-1:0]                w_c [3];
	logic [WW-1:0]                rest_c;
	logic signed [PSW-1:0]        s_c [3];
	logic signed [RW-1:0]         sh_c [3];

	logic [WW-1:0]                w_s1 [3];
	region_t                      rgn_s1;
	logic                         dgn_s1;
	logic [8:0][COORD_BITS-1:0]   vtx_s1;

	logic signed [PRW-1:0]        prod_s2 [3][3];
	logic [WW-1:0]                w_s2 [3];
	region_t                      rgn_s2;
	logic                         dgn_s2;

	logic signed [COORD_BITS-1:0] near_s3 [3];
	logic [WW-1:0]                w_s3 [3];
	region_t                      rgn_s3;
	logic                         dgn_s3;

	logic                         vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Weights per region; in the interior weight c is capped so the sum stays one.
	always_comb begin
		w_c[0] = '0;
		w_c[1] = '0;
		w_c[2] = '0;
		rest_c = ONE - q[0];
		case (rgn_in)
			REG_A: begin
				w_c[0] = ONE;
			end
			REG_B: begin
				w_c[1] = ONE;
			end
			REG_AB: begin
				w_c[1] = q[0];
				w_c[0] = ONE - q[0];
			end
			REG_C: begin
				w_c[2] = ONE;
			end
			REG_AC: begin
				w_c[2] = q[1];
				w_c[0] = ONE - q[1];
			end
			REG_BC: begin
				w_c[2] = q[1];
				w_c[1] = ONE - q[1];
			end
			REG_IN: begin
				if (dz) begin
					w_c[0] = ONE;
				end else begin
					w_c[1] = q[0];
					w_c[2] = (q[1] > rest_c) ? rest_c : q[1];
					w_c[0] = rest_c - w_c[2];
				end
			end
			default: begin
				w_c[0] = ONE;
			end
		endcase
	end

	// Stage 1: weights.
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1   <= w_c;
			rgn_s1 <= rgn_in;
			dgn_s1 <= (rgn_in == REG_IN) && dz;
			vtx_s1 <= vtx;
		end
	end

	// Stage 2: weight times vertex coordinate.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[k][j] <= PRW'($signed({1'b0, w_s1[j]}))
						* PRW'($signed(vtx_s1[3 * j + k]));
				end
			end
			w_s2   <= w_s1;
			rgn_s2 <= rgn_s1;
			dgn_s2 <= dgn_s1;
		end
	end

	// Sum and round half up; stage 3 saturates to the coordinate range.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_c[k]  = PSW'(prod_s2[k][0]) + PSW'(prod_s2[k][1]) + PSW'(prod_s2[k][2]) + HALF;
			sh_c[k] = RW'(s_c[k] >>> WEIGHT_FRAC_BITS);
		end
	end

	// Stage 3: output register.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (sh_c[k] > LIM) begin
					near_s3[k] <= COORD_BITS'(LIM);
				end else if (sh_c[k] < MINV) begin
					near_s3[k] <= COORD_BITS'(MINV);
				end else begin
					near_s3[k] <= COORD_BITS'(sh_c[k]);
				end
			end
			w_s3   <= w_s2;
			rgn_s3 <= rgn_s2;
			dgn_s3 <= dgn_s2;
		end
	end

	assign out_vld = vld_s3;
	assign near    = near_s3;
	assign w       = w_s3;
	assign rgn_out = rgn_s3;
	assign dgn     = dgn_s3;

endmodule

// File: rtl/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Closest point on a triangle to a query point, with barycentric weights
// and the Voronoi region code, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_ready     | query_*, vertex_a_*, vertex_b_*, vertex_c_*
//  out     | out_valid / out_ready   | near_*, weight_*, region, degenerate
//
// One item enters per cycle while the output is not stalled; the divider resolves
// one quotient bit per stage.
// Reset clears only the valid bits of every stage.
// When a result waits at the output and out_ready is low, the whole pipeline
// holds and in_ready falls; nothing is dropped or repeated.
module closest_point_on_triangle #(
	parameter int  COORD_BITS       = cpt_pkg::CPT_COORD_BITS,
	parameter int  WEIGHT_FRAC_BITS = cpt_pkg::CPT_WEIGHT_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COORD_BITS-1:0]   query_x,
	input  logic signed [COORD_BITS-1:0]   query_y,
	input  logic signed [COORD_BITS-1:0]   query_z,
	input  logic signed [COORD_BITS-1:0]   vertex_a_x,
	input  logic signed [COORD_BITS-1:0]   vertex_a_y,
	input  logic signed [COORD_BITS-1:0]   vertex_a_z,
	input  logic signed [COORD_BITS-1:0]   vertex_b_x,
	input  logic signed [COORD_BITS-1:0]   vertex_b_y,
	input  logic signed [COORD_BITS-1:0]   vertex_b_z,
	input  logic signed [COORD_BITS-1:0]   vertex_c_x,
	input  logic signed [COORD_BITS-1:0]   vertex_c_y,
	input  logic signed [COORD_BITS-1:0]   vertex_c_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_BITS-1:0]   near_x,
	output logic signed [COORD_BITS-1:0]   near_y,
	output logic signed [COORD_BITS-1:0]   near_z,
	output logic [WEIGHT_FRAC_BITS:0]      weight_a,
	output logic [WEIGHT_FRAC_BITS:0]      weight_b,
	output logic [WEIGHT_FRAC_BITS:0]      weight_c,
	output logic [2:0]                     region,
	output logic                           degenerate
);

	import cpt_pkg::*;

	localparam int DOTW = 2 * COORD_BITS + 4;
	localparam int NW   = 4 * COORD_BITS + 11;
	localparam int WW   = WEIGHT_FRAC_BITS + 1;
	localparam int VXW  = 9 * COORD_BITS;
	localparam int SBW  = 3 + VXW;
	localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS;

	logic                         en;
	logic signed [COORD_BITS-1:0] p_in [3];
	logic signed [COORD_BITS-1:0] a_in [3];
	logic signed [COORD_BITS-1:0] b_in [3];
	logic signed [COORD_BITS-1:0] c_in [3];

	logic                         dot_vld;
	logic signed [DOTW-1:0]       dot_d [6];
	logic [8:0][COORD_BITS-1:0]   dot_vtx;

	logic                         reg_vld;
	region_t                      reg_rgn;
	logic signed [NW-1:0]         reg_num [CPT_LANES];
	logic signed [NW-1:0]         reg_den [CPT_LANES];
	logic [8:0][COORD_BITS-1:0]   reg_vtx;

	logic                         div_vld;
	logic [WW-1:0]                div_q [CPT_LANES];
	logic                         div_dz [CPT_LANES];
	logic [SBW-1:0]               div_side;
	region_t                      div_rgn;
	logic [8:0][COORD_BITS-1:0]   div_vtx;

	logic signed [COORD_BITS-1:0] bl_near [3];
	logic [WW-1:0]                bl_w [3];
	region_t                      bl_rgn;

	// The whole pipeline advances unless a result is waiting at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign p_in[0] = query_x;
	assign p_in[1] = query_y;
	assign p_in[2] = query_z;
	assign a_in[0] = vertex_a_x;
	assign a_in[1] = vertex_a_y;
	assign a_in[2] = vertex_a_z;
	assign b_in[0] = vertex_b_x;
	assign b_in[1] = vertex_b_y;
	assign b_in[2] = vertex_b_z;
	assign c_in[0] = vertex_c_x;
	assign c_in[1] = vertex_c_y;
	assign c_in[2] = vertex_c_z;

	cpt_dot #(
		.COORD_BITS (COORD_BITS)
	) u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.p       (p_in),
		.a       (a_in),
		.b       (b_in),
		.c       (c_in),
		.out_vld (dot_vld),
		.d       (dot_d),
		.vtx     (dot_vtx)
	);

	cpt_region #(
		.COORD_BITS (COORD_BITS)
	) u_region (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dot_vld),
		.d       (dot_d),
		.vtx_in  (dot_vtx),
		.out_vld (reg_vld),
		.rgn     (reg_rgn),
		.num     (reg_num),
		.den     (reg_den),
		.vtx_out (reg_vtx)
	);

	cpt_div #(
		.COORD_BITS       (COORD_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.SBW              (SBW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (reg_vld),
		.num      (reg_num),
		.den      (reg_den),
		.side_in  ({reg_rgn, reg_vtx}),
		.out_vld  (div_vld),
		.q        (div_q),
		.dz       (div_dz),
		.side_out (div_side)
	);

	assign div_rgn = region_t'(div_side[SBW-1 -: 3]);
	assign div_vtx = div_side[VXW-1:0];

	cpt_blend #(
		.COORD_BITS       (COORD_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.rgn_in  (div_rgn),
		.q       (div_q),
		.dz      (div_dz[0]),
		.vtx     (div_vtx),
		.out_vld (out_valid),
		.near    (bl_near),
		.w       (bl_w),
		.rgn_out (bl_rgn),
		.dgn     (degenerate)
	);

	assign near_x   = bl_near[0];
	assign near_y   = bl_near[1];
	assign near_z   = bl_near[2];
	assign weight_a = bl_w[0];
	assign weight_b = bl_w[1];
	assign weight_c = bl_w[2];
	assign region   = bl_rgn;

`ifndef NO_ASSERTIONS
	// The three weights of every result add up to exactly one.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((WW+1)'(weight_a) + (WW+1)'(weight_b) + (WW+1)'(weight_c)
			== (WW+1)'(ONE)))
		else $error("weights do not sum to one");

	// A degenerate result only comes from the interior and sits on vertex a.
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> region == REG_IN && weight_a == ONE)
		else $error("degenerate flag outside the interior case");

	// The vertex b region carries the full weight on vertex b.
	a_vertex_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == REG_B |-> weight_b == ONE)
		else $error("vertex b region without full weight on b");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest-point-on-triangle testbench
// Drives query points and triangles through the valid/ready input, predicts
// the nearest point, barycentric weights, region code and degenerate flag
// with exact integer arithmetic, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
	import cpt_pkg::*;

	localparam int CB = CPT_COORD_BITS;
	localparam int WF = CPT_WEIGHT_FRAC_BITS;
	localparam int LATENCY = WF + 14;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic [WF:0] weight_t;

	typedef struct {
		coord_t p[3];
		coord_t a[3];
		coord_t b[3];
		coord_t c[3];
	} query_item_t;

	typedef struct {
		coord_t near[3];
		weight_t wa, wb, wc;
		region_t reg_code;
		logic degen;
	} nearest_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t query_x = '0, query_y = '0, query_z = '0;
	coord_t vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
	coord_t vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
	coord_t vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t near_x, near_y, near_z;
	weight_t weight_a, weight_b, weight_c;
	logic [2:0] region;
	logic degenerate;

	nearest_t pending_results[$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	closest_point_on_triangle uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.query_x(query_x), .query_y(query_y), .query_z(query_z),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
		.region(region), .degenerate(degenerate)
	);

	always #5 clk = ~clk;

	// Clamped quotient num/den in Q1.WF, rounded half up.
	function automatic weight_t clamped_ratio(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] n, d;
		logic [63:0] q;
		if (den == 0 || num == 0 || (num < 0) != (den < 0))
			return '0;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		if (n >= d)
			return weight_t'(1) << WF;
		q = 0;
		for (int i = 0; i < WF + 1; i++) begin
			n = n << 1;
			q = q << 1;
			if (n >= d) begin
				n = n - d;
				q = q | 1;
			end
		end
		return weight_t'((q + 1) >> 1);
	endfunction

	// Weighted vertex blend, rounded ties up, saturated to the coordinate range.
	function automatic coord_t blend_coord(longint ca, longint cbv, longint cc,
			longint wa, longint wb, longint wc);
		longint s, r, lim;
		s = wa * ca + wb * cbv + wc * cc + (longint'(1) << (WF - 1));
		r = s >>> WF;
		lim = (longint'(1) << (CB - 1)) - 1;
		if (r > lim) r = lim;
		if (r < -lim - 1) r = -lim - 1;
		return coord_t'(r);
	endfunction

	function automatic nearest_t nearest_point(query_item_t q);
		nearest_t e;
		longint p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3];
		longint d1, d2, d3, d4, d5, d6;
		logic signed [127:0] va, vb, vc, den;
		longint one, wa, wb, wc;
		one = longint'(1) << WF;
		wa = one; wb = 0; wc = 0;
		e.degen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			p[i] = q.p[i]; a[i] = q.a[i]; b[i] = q.b[i]; c[i] = q.c[i];
			ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i];
			ap[i] = p[i] - a[i]; bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i];
		end
		d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
		d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
		d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
		d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
		d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
		d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
		vc = 128'(d1) * 128'(d4) - 128'(d3) * 128'(d2);
		vb = 128'(d5) * 128'(d2) - 128'(d1) * 128'(d6);
		va = 128'(d3) * 128'(d6) - 128'(d5) * 128'(d4);
		if (d1 <= 0 && d2 <= 0) begin
			e.reg_code = REG_A;
		end else if (d3 >= 0 && d4 <= d3) begin
			wa = 0; wb = one; e.reg_code = REG_B;
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			wb = clamped_ratio(128'(d1), 128'(d1 - d3));
			wa = one - wb; e.reg_code = REG_AB;
		end else if (d6 >= 0 && d5 <= d6) begin
			wa = 0; wc = one; e.reg_code = REG_C;
		end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			wc = clamped_ratio(128'(d2), 128'(d2 - d6));
			wa = one - wc; e.reg_code = REG_AC;
		end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
			wc = clamped_ratio(128'(d4 - d3), 128'((d4 - d3) + (d5 - d6)));
			wa = 0; wb = one - wc; e.reg_code = REG_BC;
		end else begin
			e.reg_code = REG_IN;
			den = va + vb + vc;
			if (den == 0) begin
				e.degen = 1'b1;
			end else begin
				wb = clamped_ratio(vb, den);
				wc = clamped_ratio(vc, den);
				if (wc > one - wb) wc = one - wb;
				wa = one - wb - wc;
			end
		end
		for (int i = 0; i < 3; i++)
			e.near[i] = blend_coord(a[i], b[i], c[i], wa, wb, wc);
		e.wa = weight_t'(wa); e.wb = weight_t'(wb); e.wc = weight_t'(wc);
		return e;
	endfunction

	// Present one item, with a random idle gap first, and wait for acceptance.
	// Valid only falls while the sender idles, so items can follow back to back.
	task automatic send_query(query_item_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		query_x <= q.p[0]; query_y <= q.p[1]; query_z <= q.p[2];
		vertex_a_x <= q.a[0]; vertex_a_y <= q.a[1]; vertex_a_z <= q.a[2];
		vertex_b_x <= q.b[0]; vertex_b_y <= q.b[1]; vertex_b_z <= q.b[2];
		vertex_c_x <= q.c[0]; vertex_c_y <= q.c[1]; vertex_c_z <= q.c[2];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.insert(pending_results.size(), nearest_point(q));
	endtask

	function automatic coord_t rand_coord(int span);
		if (span >= 32768)
			return coord_t'($urandom);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	function automatic query_item_t rand_query(int span);
		query_item_t q;
		for (int i = 0; i < 3; i++) begin
			q.p[i] = rand_coord(span); q.a[i] = rand_coord(span);
			q.b[i] = rand_coord(span); q.c[i] = rand_coord(span);
		end
		return q;
	endfunction

	function automatic query_item_t make_query(int px, int py, int pz,
			int ax, int ay, int az, int bx, int by, int bz, int cx, int cy, int cz);
		query_item_t q;
		q.p = '{coord_t'(px), coord_t'(py), coord_t'(pz)};
		q.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
		q.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
		q.c = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
		return q;
	endfunction

	// Receiver: random stalls and in-order comparison against predictions.
	always @(posedge clk) begin
		nearest_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual region %0d",
					$time, region);
				failures++;
			end else begin
				e = pending_results.pop_front();
				if (near_x !== e.near[0] || near_y !== e.near[1] || near_z !== e.near[2]) begin
					$display("%0t: near expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)", $time,
						e.near[0], e.near[1], e.near[2], near_x, near_y, near_z);
					failures++;
				end
				if (weight_a !== e.wa || weight_b !== e.wb || weight_c !== e.wc) begin
					$display("%0t: weights expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)",
						$time, e.wa, e.wb, e.wc, weight_a, weight_b, weight_c);
					failures++;
				end
				if (region !== e.reg_code) begin
					$display("%0t: region expected %0d actual %0d", $time, e.reg_code, region);
					failures++;
				end
				if (degenerate !== e.degen) begin
					$display("%0t: degenerate expected %0d actual %0d", $time, e.degen,
						degenerate);
					failures++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Directed cases: every region, extremes, coincident and collinear vertices.
	task automatic test_directed();
		send_query(make_query(-5, -5, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(150, -5, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(40, -30, 7, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(-3, 150, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(-30, 33, 2, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(80, 80, -9, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(20, 30, 50, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(33, 33, 0, 0, 0, 0, 99, 0, 0, 0, 99, 0));
		// Collinear and coincident vertices.
		send_query(make_query(5, 1, 0, 0, 0, 0, 10, 0, 0, 5, 0, 0));
		send_query(make_query(3, 4, 5, 7, 7, 7, 7, 7, 7, 7, 7, 7));
		send_query(make_query(3, 4, 5, 0, 0, 0, 0, 0, 0, 9, 9, 9));
		send_query(make_query(30, 4, 5, 0, 0, 0, 9, 9, 9, 9, 9, 9));
		send_query(make_query(4, 6, 0, 0, 0, 0, 10, 0, 0, 20, 0, 0));
		// Extremes of the coordinate range.
		send_query(make_query(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, -32768, -32768, 32767, -32768));
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, 32767, 32767, -32768, 32767));
		send_query(make_query(0, 0, 0, -32768, -32768, 0, 32767, -32768, 0,
			0, 32767, 0));
		send_query(make_query(-1, -1, -1, 32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_query(make_query(21845, 21845, 21845, 32767, 0, 0, 0, 32767, 0,
			0, 0, 32767));
		send_query(make_query(-21846, -21846, -21846, -32768, 0, 0, 0, -32768, 0,
			0, 0, -32768));
	endtask

	// Random triangles, mostly full range with some small ones and degenerate ones.
	task automatic test_random(int count);
		query_item_t q;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1: q = rand_query(64);
				2: begin
					q = rand_query(32768);
					q.c = q.b;
				end
				3: begin
					q = rand_query(1000);
					for (int i = 0; i < 3; i++)
						q.c[i] = q.a[i] + 2 * (q.b[i] - q.a[i]);
				end
				default: q = rand_query(32768);
			endcase
			send_query(q);
		end
	endtask

	// Drop valid after the last item and wait for every result to come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 36; recv_idle_pct = 85;
		test_directed();
		test_random(130);
		send_idle_pct = 85; recv_idle_pct = 36;
		test_random(130);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(130);
		drain();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
